// ===== sv/adcema_pkg.sv =====
package adcema_pkg;

  // field widths
  localparam int CODE_W = 24;
  localparam int UV_W   = 22;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd1;

  // reset values of the registers
  localparam logic [CFG_W-1:0] GAIN_RST   = 8'd16;
  localparam logic [CFG_W-1:0] WINDOW_RST = 8'd1;

  // scaling: code * 2048000 / (gain * 2^23) == (code * 125 / 2^9) / gain
  localparam int PROD_W  = 32;
  localparam int SCALE_SH = 9;

  // shared divider dividend width (covers |uv| and |uv - avg|)
  localparam int DIVD_W = 22;
  localparam int CNT_W  = $clog2(DIVD_W);

  // saturation threshold on the signed code
  localparam logic signed [CODE_W-1:0] SAT_LIMIT = 24'sd8388592;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_res_t;

endpackage

// ===== sv/adc_code_to_microvolt_ema.sv =====
// converter code to microvolt scaler with optional exponential average
//
// input channel: in_valid / in_stall with in_raw_code, a 24-bit two's
// complement code. output channel: out_valid / out_stall with
// out_level_uv (signed microvolts) and out_saturated.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is gain, index 1 is window. any write to either clears the
// running average. cfg_ready is always high; write only while idle.
//
// one item at a time: one shared serial divider (one quotient bit per
// cycle, 22 bits, then a registered done) does the gain divide and, with
// the filter active and the average nonzero, the window divide. the
// result then passes through S_OUT into the output register; in_stall
// is high from the input transfer until that load and drops in the cycle
// the result shows on out_valid, when the next item can be taken.
// the result sits in an output register; the next item is taken while it
// waits. if out_stall holds a result and a newer one is done, the newer
// one waits inside and the block stays stalled on input.
// reset: gain 16, window 1, average zero, no result pending.
module adc_code_to_microvolt_ema
  import adcema_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CODE_W-1:0]      in_raw_code,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [UV_W-1:0] out_level_uv,
  output logic                   out_saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DIV_UV  = 2'd1;
  localparam logic [1:0] S_DIV_AVG = 2'd2;
  localparam logic [1:0] S_OUT     = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CFG_W-1:0]       gain_r, gain_nxt;
  logic [CFG_W-1:0]       window_r, window_nxt;
  logic signed [UV_W-1:0] avg_r, avg_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sat_r, sat_nxt;
  logic signed [UV_W-1:0] res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [UV_W-1:0] out_value_r, out_value_nxt;
  logic                   out_sat_r, out_sat_nxt;

  logic                   accept;
  logic signed [CODE_W-1:0] code;
  logic signed [PROD_W-1:0] code_x;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic signed [UV_W-1:0]   q_signed;
  logic signed [UV_W-1:0]   uv;
  logic signed [UV_W:0]     diff;
  logic [UV_W:0]            diff_mag;

  logic                   div_start;
  logic [DIVD_W-1:0]      div_dividend;
  logic [CFG_W-1:0]       div_divisor;
  div_res_t               div_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // code * 125 by shift and add, then magnitude scaled down by 2^9
  assign code     = $signed(in_raw_code);
  assign code_x   = PROD_W'(code);
  assign prod     = (code_x <<< 7) - (code_x <<< 2) + code_x;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  // signed quotient, shared by both divide phases
  assign q_signed = neg_r ? -$signed(UV_W'(div_res.quotient))
                          : $signed(UV_W'(div_res.quotient));
  assign uv       = q_signed;
  assign diff     = (UV_W+1)'(uv) - (UV_W+1)'(avg_r);
  assign diff_mag = diff[UV_W] ? (UV_W+1)'(-diff) : (UV_W+1)'(diff);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    window_nxt    = window_r;
    avg_nxt       = avg_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    div_start     = 1'b0;
    div_dividend  = prod_mag[SCALE_SH +: DIVD_W];
    div_divisor   = (gain_r == '0) ? CFG_W'(1) : gain_r;

    // output register drains on transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // register writes
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GAIN) begin
        gain_nxt = cfg_data;
        avg_nxt  = '0;
      end else if (cfg_index == REG_WINDOW) begin
        window_nxt = cfg_data;
        avg_nxt    = '0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = prod[PROD_W-1];
          sat_nxt   = (code >= SAT_LIMIT) || (code <= -SAT_LIMIT);
          div_start = 1'b1;
          state_nxt = S_DIV_UV;
        end
      end
      S_DIV_UV: begin
        if (div_res.done) begin
          if (window_r > CFG_W'(1)) begin
            if (avg_r == '0) begin
              avg_nxt   = uv;
              res_nxt   = uv;
              state_nxt = S_OUT;
            end else begin
              neg_nxt      = diff[UV_W];
              div_dividend = diff_mag[DIVD_W-1:0];
              div_divisor  = window_r;
              div_start    = 1'b1;
              state_nxt    = S_DIV_AVG;
            end
          end else begin
            res_nxt   = uv;
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV_AVG: begin
        if (div_res.done) begin
          avg_nxt   = avg_r + q_signed;
          res_nxt   = avg_r + q_signed;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RST;
      window_r    <= WINDOW_RST;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      window_r    <= window_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    sat_r       <= sat_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  // shared serial divider
  adcema_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  assign out_valid     = out_valid_r;
  assign out_level_uv  = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== sv/adcema_div.sv =====
module adcema_div
  import adcema_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output div_res_t          res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  dvs_r, dvs_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [CFG_W:0]    shifted;
  logic              ge;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? CFG_W'(shifted - {1'b0, dvs_r}) : shifted[CFG_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule
